@@ rtl/ilir_pkg.sv @@
// Package for the indexed list block: sizes, codes and the cell control word.
package ilir_pkg;

  localparam int CAPACITY     = 64;
  localparam int ELEMENT_BITS = 32;

  // Count and position width: positions run up to CAPACITY for an insert at the end.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int POS_W = CNT_W;

  // Cells per registered group of the read tree.
  localparam int GROUP_SIZE = 8;
  localparam int GROUPS     = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  // Widths of the port fields.
  localparam int CMD_W    = 2;
  localparam int INDEX_W  = 8;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_POP    = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_OOB  = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_e;

  // Control word broadcast to every cell in the chain.
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic                    rd;
    logic [POS_W-1:0]        pos;
    logic [ELEMENT_BITS-1:0] elem;
  } cell_ctl_t;

endpackage

@@ rtl/ilir_in_if.sv @@
// Channel interfaces: command beats in and result beats out.
interface ilir_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [ilir_pkg::CMD_W-1:0]            cmd;
  logic signed [ilir_pkg::INDEX_W-1:0]   index;
  logic [ilir_pkg::HANDLE_W-1:0]         element;

  modport source (output valid, output cmd, output index, output element, input ready);
  modport sink (input valid, input cmd, input index, input element, output ready);
endinterface

interface ilir_out_if;
  logic                            valid;
  logic                            ready;
  logic [ilir_pkg::HANDLE_W-1:0]   read_element;
  logic [ilir_pkg::STATUS_W-1:0]   status;
  logic [ilir_pkg::COUNT_W-1:0]    count;

  modport source (output valid, output read_element, output status, output count,
                  input ready);
  modport sink (input valid, input read_element, input status, input count,
                output ready);
endinterface

@@ rtl/ilir_cell.sv @@
// One list cell: holds an element and trades it with its neighbors on insert and pop.
module ilir_cell (
  input  logic                                 clk_i,
  input  ilir_pkg::cell_ctl_t                  ctl_i,
  input  logic [ilir_pkg::POS_W-1:0]           idx_i,
  input  logic [ilir_pkg::ELEMENT_BITS-1:0]    left_i,
  input  logic [ilir_pkg::ELEMENT_BITS-1:0]    right_i,
  output logic [ilir_pkg::ELEMENT_BITS-1:0]    data_o,
  output logic [ilir_pkg::ELEMENT_BITS-1:0]    hit_o
);

  logic [ilir_pkg::ELEMENT_BITS-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.ins) begin
      if (idx_i > ctl_i.pos) begin
        data_d = left_i;
      end else if (idx_i == ctl_i.pos) begin
        data_d = ctl_i.elem;
      end
    end else if (ctl_i.del && (idx_i >= ctl_i.pos)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign hit_o  = (ctl_i.rd && (idx_i == ctl_i.pos)) ? data_q : '0;

endmodule

@@ rtl/ilir_chain.sv @@
// Row of list cells with a registered first level of the read-out OR tree.
module ilir_chain (
  input  logic                                clk_i,
  input  ilir_pkg::cell_ctl_t                 ctl_i,
  output logic [ilir_pkg::ELEMENT_BITS-1:0]   part_o [ilir_pkg::GROUPS]
);

  logic [ilir_pkg::ELEMENT_BITS-1:0] data_w  [ilir_pkg::CAPACITY];
  logic [ilir_pkg::ELEMENT_BITS-1:0] left_w  [ilir_pkg::CAPACITY];
  logic [ilir_pkg::ELEMENT_BITS-1:0] right_w [ilir_pkg::CAPACITY];
  logic [ilir_pkg::ELEMENT_BITS-1:0] hit_w   [ilir_pkg::CAPACITY];
  logic [ilir_pkg::ELEMENT_BITS-1:0] part_q  [ilir_pkg::GROUPS];
  logic [ilir_pkg::ELEMENT_BITS-1:0] part_d  [ilir_pkg::GROUPS];

  for (genvar i = 0; i < ilir_pkg::CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = '0;
    end else begin : g_mid
      assign left_w[i] = data_w[i-1];
    end
    if (i == ilir_pkg::CAPACITY - 1) begin : g_last
      assign right_w[i] = '0;
    end else begin : g_rest
      assign right_w[i] = data_w[i+1];
    end

    ilir_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl_i),
      .idx_i   (ilir_pkg::POS_W'(i)),
      .left_i  (left_w[i]),
      .right_i (right_w[i]),
      .data_o  (data_w[i]),
      .hit_o   (hit_w[i])
    );
  end

  // At most one cell hits, so each group reduces by OR.
  always_comb begin
    for (int g = 0; g < ilir_pkg::GROUPS; g++) begin
      part_d[g] = '0;
      for (int j = 0; j < ilir_pkg::GROUP_SIZE; j++) begin
        if (g * ilir_pkg::GROUP_SIZE + j < ilir_pkg::CAPACITY) begin
          part_d[g] = part_d[g] | hit_w[g * ilir_pkg::GROUP_SIZE + j];
        end
      end
    end
  end

  // The group results are held until the next read, so a stalled result keeps them.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      part_q <= part_d;
    end
  end

  assign part_o = part_q;

endmodule

@@ rtl/indexed_list_insert_remove.sv @@
// Top level of the indexed list: command decode, index resolution and result register.
//
//   channel | dir | beat fields                    | accepted when
//   --------+-----+--------------------------------+-------------------------
//   in_i    | in  | cmd, index, element            | in_i.valid && in_i.ready
//   out_o   | out | read_element, status, count    | out_o.valid && out_o.ready
//
// Each command beat runs through the accept, execute and done steps: accept resolves
// the signed index against the current count, execute lets every cell of the chain
// shift or load in parallel while the read tree captures its group results, and done
// folds the groups into the result register. A new beat is taken only back in idle,
// so the block never takes a command before the last one is loaded for output. The
// result register parts the two sides; a stalled result holds the finished command
// in the last step until it is taken. Reset clears the count and the control state;
// the cell contents are left as they are and only written positions are ever read.
module indexed_list_insert_remove (
  input  logic        clk_i,
  input  logic        rst_ni,
  ilir_in_if.sink     in_i,
  ilir_out_if.source  out_o
);

  localparam int IW = ilir_pkg::CNT_W + ilir_pkg::INDEX_W + 1;
  localparam int EW = ilir_pkg::ELEMENT_BITS + ilir_pkg::HANDLE_W;
  localparam int CW = ilir_pkg::CNT_W + ilir_pkg::COUNT_W;

  ilir_pkg::state_e state_q, state_d;

  logic [ilir_pkg::CNT_W-1:0]        count_q, count_d;
  logic [ilir_pkg::CMD_W-1:0]        cmd_q;
  logic [ilir_pkg::POS_W-1:0]        pos_q;
  logic [ilir_pkg::ELEMENT_BITS-1:0] elem_q;
  logic [ilir_pkg::STATUS_W-1:0]     stat_q;

  logic                              out_valid_q, out_valid_d;
  logic [ilir_pkg::HANDLE_W-1:0]     out_elem_q;
  logic [ilir_pkg::STATUS_W-1:0]     out_stat_q;
  logic [ilir_pkg::COUNT_W-1:0]      out_count_q;

  logic                              in_fire, load_out;
  logic signed [IW-1:0]              idx_s, n_s, neg_s, pos_s;
  logic                              ok_ins, ok_rd, full;
  logic [ilir_pkg::STATUS_W-1:0]     stat_new;
  logic [ilir_pkg::POS_W-1:0]        pos_new;
  logic [EW-1:0]                     in_elem_w, out_elem_w;
  logic [CW-1:0]                     count_w;
  logic [ilir_pkg::ELEMENT_BITS-1:0] fold;
  logic                              is_ok, is_pop, is_read, is_push, is_ins;

  ilir_pkg::cell_ctl_t               ctl;
  logic [ilir_pkg::ELEMENT_BITS-1:0] part_w [ilir_pkg::GROUPS];

  assign in_fire = in_i.valid && in_i.ready;

  // Signed index resolution against the count at accept time.
  assign idx_s  = IW'(in_i.index);
  assign n_s    = IW'(count_q);
  assign neg_s  = -idx_s;
  assign pos_s  = (idx_s >= 0) ? idx_s : n_s + idx_s;
  assign ok_ins = (idx_s >= 0) ? (idx_s <= n_s) : (neg_s <= n_s);
  assign ok_rd  = (count_q != '0) && ((idx_s >= 0) ? (idx_s < n_s) : (neg_s <= n_s));
  assign full   = (count_q == ilir_pkg::CNT_W'(ilir_pkg::CAPACITY));

  always_comb begin
    stat_new = ilir_pkg::STAT_OK;
    pos_new  = pos_s[ilir_pkg::POS_W-1:0];
    case (in_i.cmd)
      ilir_pkg::CMD_PUSH: begin
        // A push is an insert at the end of the list.
        pos_new = count_q;
        if (full) stat_new = ilir_pkg::STAT_FULL;
      end
      ilir_pkg::CMD_INSERT: begin
        if (!ok_ins)   stat_new = ilir_pkg::STAT_OOB;
        else if (full) stat_new = ilir_pkg::STAT_FULL;
      end
      default: begin
        if (!ok_rd) stat_new = ilir_pkg::STAT_OOB;
      end
    endcase
  end

  assign in_elem_w = EW'(in_i.element);

  assign is_ok   = (stat_q == ilir_pkg::STAT_OK);
  assign is_push = (cmd_q == ilir_pkg::CMD_PUSH);
  assign is_ins  = (cmd_q == ilir_pkg::CMD_INSERT);
  assign is_pop  = (cmd_q == ilir_pkg::CMD_POP);
  assign is_read = (cmd_q == ilir_pkg::CMD_READ);

  // The cells act only in the execute step.
  always_comb begin
    ctl.ins  = (state_q == ilir_pkg::ST_EXEC) && is_ok && (is_push || is_ins);
    ctl.del  = (state_q == ilir_pkg::ST_EXEC) && is_ok && is_pop;
    ctl.rd   = (state_q == ilir_pkg::ST_EXEC) && is_ok && (is_pop || is_read);
    ctl.pos  = pos_q;
    ctl.elem = elem_q;
  end

  ilir_chain u_chain (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .part_o (part_w)
  );

  always_comb begin
    fold = '0;
    for (int g = 0; g < ilir_pkg::GROUPS; g++) begin
      fold = fold | part_w[g];
    end
  end

  assign out_elem_w = EW'(fold);
  assign count_w    = CW'(count_q);

  // Sequencer: next state, count update and result load.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    load_out    = 1'b0;
    in_i.ready  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    case (state_q)
      ilir_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) state_d = ilir_pkg::ST_EXEC;
      end
      ilir_pkg::ST_EXEC: begin
        if (is_ok && (is_push || is_ins)) count_d = count_q + 1'b1;
        else if (is_ok && is_pop)         count_d = count_q - 1'b1;
        state_d = ilir_pkg::ST_DONE;
      end
      ilir_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ilir_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ilir_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ilir_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= in_i.cmd;
      pos_q  <= pos_new;
      elem_q <= in_elem_w[ilir_pkg::ELEMENT_BITS-1:0];
      stat_q <= stat_new;
    end
    if (load_out) begin
      out_elem_q  <= (is_ok && (is_pop || is_read)) ? out_elem_w[ilir_pkg::HANDLE_W-1:0] : '0;
      out_stat_q  <= stat_q;
      out_count_q <= count_w[ilir_pkg::COUNT_W-1:0];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.read_element = out_elem_q;
  assign out_o.status       = out_stat_q;
  assign out_o.count        = out_count_q;

  // The count never runs past the capacity of the chain.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ilir_pkg::CNT_W'(ilir_pkg::CAPACITY))
    else $error("list count above capacity");

  // An accepted beat always moves on to the execute step.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ilir_pkg::ST_EXEC))
    else $error("accepted beat did not start execution");

  // A successful pop shortens the list by exactly one.
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ilir_pkg::ST_EXEC) && is_ok && is_pop) |=>
      (count_q == $past(count_q) - 1'b1))
    else $error("pop did not decrement count");

  // A failed command never returns an element.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_stat_q != ilir_pkg::STAT_OK)) |-> (out_elem_q == '0))
    else $error("failed command returned an element");

endmodule

@@ tb/indexed_list_insert_remove_tb.sv @@
// Self-checking testbench for the indexed list with signed insert, pop and read positions.
module indexed_list_insert_remove_tb;

  // A stalled receiver can block every acceptance for the long hold-off, so the
  // idle limit sits well above it.
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = 20;

  typedef logic signed [ilir_pkg::INDEX_W-1:0] index_t;
  typedef logic [ilir_pkg::HANDLE_W-1:0]       handle_t;

  typedef struct {
    handle_t                        read_element;
    ilir_pkg::status_e              status;
    logic [ilir_pkg::COUNT_W-1:0]   count;
  } result_t;

  // Receiver stall patterns.
  typedef enum int {
    RX_FREE,
    RX_MOSTLY,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ilir_in_if  in_if ();
  ilir_out_if out_if ();

  indexed_list_insert_remove i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Mirror of the list contents, lowest position first, and the results that
  // the accepted command beats are due to produce, in order.
  logic [ilir_pkg::ELEMENT_BITS-1:0] list_mirror[$];
  result_t                           pending_results[$];

  int       err_cnt    = 0;
  int       idle_cnt   = 0;
  int       burst_left = 0;
  bit       hold_req   = 1'b0;
  bit       hold_taken = 1'b0;
  int       hold_left  = 0;
  rx_mode_e rx_mode    = RX_FREE;
  int       mode_left  = 0;
  int       rx_phase   = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicts the result of one command and updates the mirror. A negative index
  // counts back from the end of the list. Insert accepts -count to count; pop and
  // read accept -count to count-1 and always fail on an empty list. Bounds are
  // checked before the full-store condition on an insert.
  function automatic result_t list_apply(ilir_pkg::cmd_e cmd, index_t idx, handle_t elem);
    result_t r;
    int      n;
    int      i;
    int      pos;
    bit      in_range;
    n              = list_mirror.size();
    i              = idx;
    pos            = (i >= 0) ? i : n + i;
    r.read_element = '0;
    r.status       = ilir_pkg::STAT_OK;
    case (cmd)
      ilir_pkg::CMD_PUSH: begin
        if (n >= ilir_pkg::CAPACITY) r.status = ilir_pkg::STAT_FULL;
        else list_mirror.insert(n, elem[ilir_pkg::ELEMENT_BITS-1:0]);
      end
      ilir_pkg::CMD_INSERT: begin
        in_range = (i >= 0) ? (i <= n) : (-i <= n);
        if (!in_range) r.status = ilir_pkg::STAT_OOB;
        else if (n >= ilir_pkg::CAPACITY) r.status = ilir_pkg::STAT_FULL;
        else list_mirror.insert(pos, elem[ilir_pkg::ELEMENT_BITS-1:0]);
      end
      default: begin
        in_range = (n != 0) && ((i >= 0) ? (i <= n - 1) : (-i <= n));
        if (!in_range) begin
          r.status = ilir_pkg::STAT_OOB;
        end else begin
          r.read_element = ilir_pkg::HANDLE_W'(list_mirror[pos]);
          if (cmd == ilir_pkg::CMD_POP) list_mirror.delete(pos);
        end
      end
    endcase
    r.count = ilir_pkg::COUNT_W'(list_mirror.size());
    return r;
  endfunction

  // Picks an index for the next pop, read or insert. With wild set, about a
  // quarter of the picks fall just outside the legal range or anywhere in the
  // 8-bit field; otherwise the index is always legal (the list must then hold
  // an element for pop and read).
  function automatic int pick_index(bit for_insert, bit wild);
    int n;
    int hi;
    int r;
    n  = list_mirror.size();
    hi = for_insert ? n : n - 1;
    r  = $urandom_range(0, 99);
    if (wild && r < 15) return int'($urandom_range(0, 255)) - 128;
    if (wild && r < 25) return $urandom_range(0, 1) ? hi + 1 : -n - 1;
    if (hi < 0) return int'($urandom_range(0, 255)) - 128;
    return int'($urandom_range(0, hi + n)) - n;
  endfunction

  // Drops valid for the given number of cycles, starting at the next falling edge.
  task automatic sender_idle(int cycles);
    @(negedge clk_i);
    in_if.valid = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Offers one command beat and holds it until the block takes it. The sender
  // runs in bursts; a burst that ends is followed by a random gap, and now and
  // then a long burst gives a stretch with no gaps at all.
  task automatic send_beat(ilir_pkg::cmd_e cmd, index_t idx, handle_t elem);
    @(negedge clk_i);
    in_if.valid   = 1'b1;
    in_if.cmd     = cmd;
    in_if.index   = idx;
    in_if.element = elem;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.insert(pending_results.size(), list_apply(cmd, idx, elem));
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(30, 60);
      end else begin
        burst_left = $urandom_range(1, 16);
        sender_idle($urandom_range(1, 12));
      end
    end
  endtask

  // Stops offering beats until every pending result has been taken.
  task automatic wait_drained();
    sender_idle(1);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // One random command with a random element. The target length steers the list
  // to grow or shrink, so that runs reach both a long and an empty list.
  task automatic send_random(int target);
    ilir_pkg::cmd_e cmd;
    int             r;
    int             grow;
    r    = $urandom_range(0, 99);
    grow = (list_mirror.size() < target) ? 65 : 15;
    if (r < 20) cmd = ilir_pkg::CMD_READ;
    else if (r < 20 + grow / 2) cmd = ilir_pkg::CMD_PUSH;
    else if (r < 20 + grow) cmd = ilir_pkg::CMD_INSERT;
    else cmd = ilir_pkg::CMD_POP;
    send_beat(cmd, index_t'(pick_index(cmd == ilir_pkg::CMD_INSERT, 1'b1)), $urandom());
  endtask

  // Pop and read on an empty list must fail at any index, and an insert into an
  // empty list accepts index zero alone. Push ignores the index field.
  task automatic test_empty_list();
    send_beat(ilir_pkg::CMD_READ,    8'sd0,    32'h1234_5678);
    send_beat(ilir_pkg::CMD_READ,    -8'sd1,   32'h0);
    send_beat(ilir_pkg::CMD_POP,     8'sd0,    32'hFFFF_FFFF);
    send_beat(ilir_pkg::CMD_POP,     -8'sd128, 32'h0);
    send_beat(ilir_pkg::CMD_READ,    8'sd127,  32'h0);
    send_beat(ilir_pkg::CMD_INSERT,  8'sd1,    32'hDEAD_BEEF);
    send_beat(ilir_pkg::CMD_INSERT,  -8'sd1,   32'hDEAD_BEEF);
    send_beat(ilir_pkg::CMD_PUSH,    -8'sd128, 32'hFFFF_FFFF);
    send_beat(ilir_pkg::CMD_POP,     -8'sd1,   32'h0);
    send_beat(ilir_pkg::CMD_INSERT,  8'sd0,    32'h0000_0000);
    send_beat(ilir_pkg::CMD_POP,     8'sd0,    32'hA5A5_A5A5);
  endtask

  // Positive and negative indices at and just past both ends of a short list.
  task automatic test_signed_index();
    send_beat(ilir_pkg::CMD_PUSH,   8'sd127, 32'h0000_0001);
    send_beat(ilir_pkg::CMD_PUSH,   8'sd0,   32'h8000_0000);
    send_beat(ilir_pkg::CMD_PUSH,   -8'sd5,  32'h5A5A_A5A5);
    send_beat(ilir_pkg::CMD_READ,   -8'sd3,  32'h0);
    send_beat(ilir_pkg::CMD_READ,   -8'sd4,  32'h0);
    send_beat(ilir_pkg::CMD_READ,   8'sd3,   32'h0);
    send_beat(ilir_pkg::CMD_READ,   8'sd2,   32'h0);
    send_beat(ilir_pkg::CMD_INSERT, -8'sd3,  32'hFFFF_FFFF);
    send_beat(ilir_pkg::CMD_INSERT, 8'sd4,   32'h7FFF_FFFE);
    send_beat(ilir_pkg::CMD_INSERT, 8'sd6,   32'h1111_1111);
    send_beat(ilir_pkg::CMD_INSERT, -8'sd6,  32'h2222_2222);
    send_beat(ilir_pkg::CMD_POP,    8'sd2,   32'hCAFE_F00D);
    send_beat(ilir_pkg::CMD_POP,    -8'sd1,  32'h0);
  endtask

  // Fills the store to capacity with pushes and inserts at legal positions, then
  // probes it: pushes and legal inserts report a full store, inserts out of bounds
  // report a bounds failure first; reads near both ends and random commands follow.
  task automatic test_full_store();
    ilir_pkg::cmd_e cmd;
    while (list_mirror.size() < ilir_pkg::CAPACITY) begin
      if ($urandom_range(0, 1) != 0) cmd = ilir_pkg::CMD_PUSH;
      else cmd = ilir_pkg::CMD_INSERT;
      send_beat(cmd, index_t'(pick_index(1'b1, 1'b0)), $urandom());
    end
    send_beat(ilir_pkg::CMD_PUSH,   8'sd0,                               $urandom());
    send_beat(ilir_pkg::CMD_INSERT, index_t'(ilir_pkg::CAPACITY),        $urandom());
    send_beat(ilir_pkg::CMD_INSERT, index_t'(-ilir_pkg::CAPACITY),       $urandom());
    send_beat(ilir_pkg::CMD_INSERT, index_t'(pick_index(1'b1, 1'b0)),    $urandom());
    send_beat(ilir_pkg::CMD_INSERT, index_t'(ilir_pkg::CAPACITY + 1),    $urandom());
    send_beat(ilir_pkg::CMD_INSERT, index_t'(-ilir_pkg::CAPACITY - 1),   $urandom());
    send_beat(ilir_pkg::CMD_INSERT, 8'sd127,                             $urandom());
    send_beat(ilir_pkg::CMD_READ,   index_t'(-ilir_pkg::CAPACITY),       $urandom());
    send_beat(ilir_pkg::CMD_READ,   index_t'(ilir_pkg::CAPACITY - 1),    $urandom());
    send_beat(ilir_pkg::CMD_READ,   index_t'(ilir_pkg::CAPACITY),        $urandom());
    send_beat(ilir_pkg::CMD_READ,   -8'sd128,                            $urandom());
    repeat (20) send_random(ilir_pkg::CAPACITY);
  endtask

  // Empties the list by pops at random legal positions with reads in between,
  // then tries once more on the empty list.
  task automatic test_drain_to_empty();
    while (list_mirror.size() != 0) begin
      if ($urandom_range(0, 3) == 0) begin
        send_beat(ilir_pkg::CMD_READ, index_t'(pick_index(1'b0, 1'b0)), $urandom());
      end
      send_beat(ilir_pkg::CMD_POP, index_t'(pick_index(1'b0, 1'b0)), $urandom());
    end
    send_beat(ilir_pkg::CMD_POP,  index_t'(pick_index(1'b0, 1'b1)), $urandom());
    send_beat(ilir_pkg::CMD_READ, index_t'(pick_index(1'b0, 1'b1)), $urandom());
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // beats, so the block fills and stalls its input; then the sender waits
  // until every result has come out.
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (30) send_random(32);
    wait_drained();
  endtask

  // Long random mix. The target length moves every few dozen beats, and now
  // and then the sender pauses until the block has drained.
  task automatic test_random_mix();
    int target;
    target = 0;
    for (int k = 0; k < 480; k++) begin
      if (k % 40 == 0) target = $urandom_range(0, ilir_pkg::CAPACITY);
      if (k % 150 == 149) wait_drained();
      send_random(target);
    end
  endtask

  // The receiver drives ready at the falling edge. A hold-off request takes
  // over and holds ready low; otherwise one of several stall patterns runs for
  // a random stretch before the next is picked.
  always @(negedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_left  = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (mode_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    rx_phase++;
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready = 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:   out_if.ready = 1'b1;
        RX_MOSTLY: out_if.ready = ($urandom_range(0, 3) != 0);
        RX_SPARSE: out_if.ready = ($urandom_range(0, 3) == 0);
        default:   out_if.ready = ((rx_phase % 5) < 2);
      endcase
    end
  end

  // Every result beat is checked against the oldest pending prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no pending command: read_element %h status %0d count %0d",
               out_if.read_element, out_if.status, out_if.count);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.read_element !== want.read_element) begin
          $error("read_element: expected %h, actual %h", want.read_element,
                 out_if.read_element);
          err_cnt++;
        end
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_if.status);
          err_cnt++;
        end
        if (out_if.count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, out_if.count);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    in_if.valid   = 1'b0;
    in_if.cmd     = ilir_pkg::CMD_PUSH;
    in_if.index   = '0;
    in_if.element = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_list();
    test_signed_index();
    test_full_store();
    test_drain_to_empty();
    test_backpressure();
    test_random_mix();

    // Let the last beats drain, then keep watching in case anything stray
    // comes out after the final expected result.
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
